// ===== hdl/sfcp_pkg.sv =====
// Package for the strip/fan command parser: word phase type, field widths,
// result bit positions and default serial width. No dependencies.
`default_nettype none

package sfcp_pkg;

    localparam int SERIAL_BITS_DEF = 16;

    localparam int CMD_W    = 16;
    localparam int IDX_W    = 15;
    localparam int SHOW_W   = 16;
    localparam int TDATA_W  = 128;
    localparam int TUSER_W  = 3;

    // tuser flag positions
    localparam int USR_VERTEX = 0;
    localparam int USR_TRI    = 1;
    localparam int USR_DONE   = 2;

    // tdata field offsets, lowest field first
    localparam int OFS_SERIAL = 0;
    localparam int OFS_VERT   = 16;
    localparam int OFS_NORM   = 31;
    localparam int OFS_S      = 46;
    localparam int OFS_T      = 62;
    localparam int OFS_A      = 78;
    localparam int OFS_B      = 94;
    localparam int OFS_C      = 110;
    localparam int OFS_PAD    = 126;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_VERT   = 3'd1,
        PH_NORM   = 3'd2,
        PH_S      = 3'd3,
        PH_T      = 3'd4
    } phase_t;

endpackage

`default_nettype wire

// ===== hdl/strip_fan_command_parser_core.sv =====
// Strip/fan command parser: turns a mesh command word stream into vertex
// and triangle-list items. Depends on sfcp_pkg.
`default_nettype none

// Channel   Dir  Width  Contents
// s_axis    in   16     tdata: cmd_word (signed)
// m_axis    out  128/3  tdata: serial, indexes, tex s/t, corners a/b/c
//                       tuser: vertex_valid, tri_valid, stream_done
//
// One command word is taken per cycle; its result (if any) appears in the
// output register on the next cycle. The only timing element is that output
// register: s_axis_tready is low only while a result sits there unclaimed.
// Reset (rst_n low, async) returns the parser to header-word phase with all
// serial history cleared and the output register empty.
// Nonzero header words and the first three words of a vertex produce no item.

module strip_fan_command_parser_core
    import sfcp_pkg::*;
#(
    parameter int SERIAL_BITS = SERIAL_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // cmd_word [15:0]
    input  wire logic [CMD_W-1:0]     s_axis_tdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // vertex_serial[15:0] vert_index[30:16] norm_index[45:31] tex_s[61:46]
    // tex_t[77:62] corner_a[93:78] corner_b[109:94] corner_c[125:110] zeros
    output logic [TDATA_W-1:0]        m_axis_tdata,
    // vertex_valid[0] tri_valid[1] stream_done[2]
    output logic [TUSER_W-1:0]        m_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready
);

    // parser state
    phase_t                  phase_reg, phase_next;
    logic [15:0]             verts_left_reg, verts_left_next;
    logic                    strip_mode_reg, strip_mode_next;
    logic [15:0]             pos_reg, pos_next;
    logic [SERIAL_BITS-1:0]  serial_count_reg, serial_count_next;
    logic [SERIAL_BITS-1:0]  first_serial_reg, first_serial_next;
    logic [SERIAL_BITS-1:0]  prev_serial_reg, prev_serial_next;
    logic [SERIAL_BITS-1:0]  prev2_serial_reg, prev2_serial_next;
    logic [IDX_W-1:0]        held_vert_reg, held_vert_next;
    logic [IDX_W-1:0]        held_norm_reg, held_norm_next;
    logic [CMD_W-1:0]        held_s_reg, held_s_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]      out_data_reg, out_data_next;
    logic [TUSER_W-1:0]      out_user_reg, out_user_next;

    logic                    in_fire;
    logic                    has_result;
    logic [TDATA_W-1:0]      res_data;
    logic [TUSER_W-1:0]      res_user;
    logic [SERIAL_BITS-1:0]  corner_a, corner_b;
    logic [15:0]             verts_dec;

    // serials are shown in 16 bits: truncate or zero-extend
    function automatic logic [SHOW_W-1:0] show16(input logic [SERIAL_BITS-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[SHOW_W-1:0];
    endfunction

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign verts_dec     = verts_left_reg - 16'd1;

    // strips swap the older two corners on odd positions; fans pivot
    always_comb
    begin
        if (!strip_mode_reg)
        begin
            corner_a = first_serial_reg;
            corner_b = prev_serial_reg;
        end
        else if (pos_reg[0])
        begin
            corner_a = prev_serial_reg;
            corner_b = prev2_serial_reg;
        end
        else
        begin
            corner_a = prev2_serial_reg;
            corner_b = prev_serial_reg;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        verts_left_next   = verts_left_reg;
        strip_mode_next   = strip_mode_reg;
        pos_next          = pos_reg;
        serial_count_next = serial_count_reg;
        first_serial_next = first_serial_reg;
        prev_serial_next  = prev_serial_reg;
        prev2_serial_next = prev2_serial_reg;
        held_vert_next    = held_vert_reg;
        held_norm_next    = held_norm_reg;
        held_s_next       = held_s_reg;
        has_result        = 1'b0;
        res_data          = '0;
        res_user          = '0;

        case (phase_reg)
            PH_VERT:
            begin
                held_vert_next = s_axis_tdata[IDX_W-1:0];
                phase_next     = PH_NORM;
            end
            PH_NORM:
            begin
                held_norm_next = s_axis_tdata[IDX_W-1:0];
                phase_next     = PH_S;
            end
            PH_S:
            begin
                held_s_next = s_axis_tdata;
                phase_next  = PH_T;
            end
            PH_T:
            begin
                has_result = 1'b1;
                res_user[USR_VERTEX] = 1'b1;
                res_data[OFS_VERT-1:OFS_SERIAL] = show16(serial_count_reg);
                res_data[OFS_NORM-1:OFS_VERT]   = held_vert_reg;
                res_data[OFS_S-1:OFS_NORM]      = held_norm_reg;
                res_data[OFS_T-1:OFS_S]         = held_s_reg;
                res_data[OFS_A-1:OFS_T]         = s_axis_tdata;
                // third vertex of a command onward closes a triangle
                if (|pos_reg[15:1])
                begin
                    res_user[USR_TRI]         = 1'b1;
                    res_data[OFS_B-1:OFS_A]   = show16(corner_a);
                    res_data[OFS_C-1:OFS_B]   = show16(corner_b);
                    res_data[OFS_PAD-1:OFS_C] = show16(serial_count_reg);
                end
                if (pos_reg == 16'd0)
                    first_serial_next = serial_count_reg;
                serial_count_next = serial_count_reg + {{(SERIAL_BITS-1){1'b0}}, 1'b1};
                prev2_serial_next = prev_serial_reg;
                prev_serial_next  = serial_count_reg;
                pos_next          = pos_reg + 16'd1;
                verts_left_next   = verts_dec;
                phase_next        = (verts_dec == 16'd0) ? PH_HEADER : PH_VERT;
            end
            default:
            begin
                // header word, also any unused phase code
                if (s_axis_tdata == '0)
                begin
                    has_result           = 1'b1;
                    res_user[USR_DONE]   = 1'b1;
                    serial_count_next    = '0;
                    phase_next           = PH_HEADER;
                end
                else
                begin
                    // negative count: fan of -count; -32768 negates to itself
                    strip_mode_next = !s_axis_tdata[CMD_W-1];
                    verts_left_next = s_axis_tdata[CMD_W-1] ? (16'd0 - s_axis_tdata)
                                                             : s_axis_tdata;
                    pos_next        = '0;
                    phase_next      = PH_VERT;
                end
            end
        endcase
    end

    always_comb
    begin
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        if (in_fire)
        begin
            out_valid_next = has_result;
            if (has_result)
            begin
                out_data_next = res_data;
                out_user_next = res_user;
            end
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_axis_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            verts_left_reg   <= '0;
            strip_mode_reg   <= 1'b0;
            pos_reg          <= '0;
            serial_count_reg <= '0;
            first_serial_reg <= '0;
            prev_serial_reg  <= '0;
            prev2_serial_reg <= '0;
            held_vert_reg    <= '0;
            held_norm_reg    <= '0;
            held_s_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg        <= phase_next;
                verts_left_reg   <= verts_left_next;
                strip_mode_reg   <= strip_mode_next;
                pos_reg          <= pos_next;
                serial_count_reg <= serial_count_next;
                first_serial_reg <= first_serial_next;
                prev_serial_reg  <= prev_serial_next;
                prev2_serial_reg <= prev2_serial_next;
                held_vert_reg    <= held_vert_next;
                held_norm_reg    <= held_norm_next;
                held_s_reg       <= held_s_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // done items carry no vertex and no triangle
    a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USR_DONE]
        |-> !m_axis_tuser[USR_VERTEX] && !m_axis_tuser[USR_TRI])
        else $error("done item also flags vertex or triangle");

    // a triangle always comes with its closing vertex, which is corner c
    a_tri_has_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USR_TRI]
        |-> m_axis_tuser[USR_VERTEX]
            && m_axis_tdata[OFS_PAD-1:OFS_C] == m_axis_tdata[OFS_VERT-1:OFS_SERIAL])
        else $error("triangle item without matching vertex");

    // end marker clears the serial counter
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && has_result && res_user[USR_DONE] |=> serial_count_reg == '0)
        else $error("serial count not cleared by end marker");

    // results only appear from an accepted word
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire))
        else $error("output valid without accepted word");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for strip_fan_command_parser_core: drives mesh command
// words, predicts vertex/triangle/done items and checks every output item.
// Depends on sfcp_pkg and the core RTL.
`default_nettype none

module testbench
    import sfcp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int QUIET_TAIL  = 120;     // final words sent with no idling
    localparam int HOLD_EVERY  = 300;     // words between drain pauses

    // one parser output item, unpacked
    typedef struct {
        logic               vertex_valid;
        logic [15:0]        serial;
        logic [IDX_W-1:0]   vert;
        logic [IDX_W-1:0]   norm;
        logic signed [15:0] tex_s;
        logic signed [15:0] tex_t;
        logic               tri_valid;
        logic [15:0]        corner_a;
        logic [15:0]        corner_b;
        logic [15:0]        corner_c;
        logic               done;
        logic [1:0]         pad;
    } mesh_item_t;

    // command word waiting to be sent; hold makes the sender wait for all
    // outstanding items first
    typedef struct {
        logic [CMD_W-1:0] word;
        bit               hold;
    } cmd_slot_t;

    logic                 clk;
    logic                 rst_n;
    logic [CMD_W-1:0]     s_axis_tdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [TUSER_W-1:0]   m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;

    cmd_slot_t   cmd_q[$];
    mesh_item_t  parsed_q[$];

    int words_total;
    int words_issued;
    int words_taken;
    int items_checked;
    int fail_count;
    int cycle_count;
    int quiet_from;
    int next_hold_at;

    // predictor state
    phase_t      ph;
    logic [15:0] verts_left;
    logic        strip_on;
    logic [15:0] cmd_pos;
    logic [15:0] serial_next;
    logic [15:0] first_ser;
    logic [15:0] prev_ser;
    logic [15:0] prev2_ser;
    logic [14:0] hold_vert;
    logic [14:0] hold_norm;
    logic [15:0] hold_s;

    int n_vertex;
    int n_tri;
    int n_done;
    int n_strip;
    int n_fan;

    strip_fan_command_parser_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Walk the parser state by one command word and queue the item it
    // should produce, if any.
    function automatic void parse_cmd_word(input logic [15:0] w);
        mesh_item_t  r;
        logic [15:0] cur;
        r = '{default: '0};
        case (ph)
            PH_VERT:
            begin
                hold_vert = w[14:0];
                ph = PH_NORM;
            end
            PH_NORM:
            begin
                hold_norm = w[14:0];
                ph = PH_S;
            end
            PH_S:
            begin
                hold_s = w;
                ph = PH_T;
            end
            PH_T:
            begin
                cur = serial_next;
                serial_next = serial_next + 16'd1;
                r.vertex_valid = 1'b1;
                r.serial = cur;
                r.vert = hold_vert;
                r.norm = hold_norm;
                r.tex_s = hold_s;
                r.tex_t = w;
                if (cmd_pos == 16'd0)
                    first_ser = cur;
                if (cmd_pos >= 16'd2)
                begin
                    r.tri_valid = 1'b1;
                    r.corner_c = cur;
                    if (!strip_on)
                    begin
                        // fan: every triangle pivots on the command's first vertex
                        r.corner_a = first_ser;
                        r.corner_b = prev_ser;
                    end
                    else if (cmd_pos[0])
                    begin
                        // odd strip position: winding flipped
                        r.corner_a = prev_ser;
                        r.corner_b = prev2_ser;
                    end
                    else
                    begin
                        r.corner_a = prev2_ser;
                        r.corner_b = prev_ser;
                    end
                    n_tri++;
                end
                prev2_ser = prev_ser;
                prev_ser = cur;
                cmd_pos = cmd_pos + 16'd1;
                verts_left = verts_left - 16'd1;
                ph = (verts_left == 16'd0) ? PH_HEADER : PH_VERT;
                n_vertex++;
                parsed_q = {parsed_q, r};
            end
            default:
            begin
                if (w == 16'd0)
                begin
                    // end marker: done item, serial numbering restarts
                    serial_next = 16'd0;
                    ph = PH_HEADER;
                    r.done = 1'b1;
                    n_done++;
                    parsed_q = {parsed_q, r};
                end
                else
                begin
                    if (w[15])
                    begin
                        strip_on = 1'b0;
                        verts_left = 16'd0 - w;    // -32768 gives 32768 as well
                        n_fan++;
                    end
                    else
                    begin
                        strip_on = 1'b1;
                        verts_left = w;
                        n_strip++;
                    end
                    cmd_pos = 16'd0;
                    ph = PH_VERT;
                end
            end
        endcase
    endfunction

    function automatic void cmp_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void push_word(input logic [15:0] w, input bit hold);
        cmd_slot_t s;
        s.word = w;
        s.hold = hold;
        cmd_q = {cmd_q, s};
    endfunction

    function automatic void push_vertex(input logic [15:0] v, input logic [15:0] n,
                                        input logic [15:0] s, input logic [15:0] t);
        push_word(v, 1'b0);
        push_word(n, 1'b0);
        push_word(s, 1'b0);
        push_word(t, 1'b0);
    endfunction

    function automatic void push_random_vertex();
        push_vertex(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    // Sender: note accepted words at the rising edge, present the next one
    // at the falling edge.
    always
    begin : cmd_sender
        logic      took;
        cmd_slot_t nxt;
        int        gap_left;
        @(posedge clk);
        took = rst_n && s_axis_tvalid && s_axis_tready;
        if (took)
        begin
            parse_cmd_word(s_axis_tdata);
            words_taken++;
        end
        @(negedge clk);
        if (rst_n && (took || !s_axis_tvalid))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() == 0 || (cmd_q[0].hold && parsed_q.size() != 0))
                s_axis_tvalid <= 1'b0;
            else if (words_issued < quiet_from && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(1, 7) - 1;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                nxt = cmd_q.pop_front();
                s_axis_tdata <= nxt.word;
                s_axis_tvalid <= 1'b1;
                words_issued++;
            end
        end
    end

    // Receiver: check each accepted item against the oldest prediction and
    // stall tready in random bursts.
    always
    begin : item_checker
        mesh_item_t got;
        mesh_item_t want;
        int         stall_left;
        @(posedge clk);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.serial       = m_axis_tdata[OFS_SERIAL +: SHOW_W];
            got.vert         = m_axis_tdata[OFS_VERT +: IDX_W];
            got.norm         = m_axis_tdata[OFS_NORM +: IDX_W];
            got.tex_s        = m_axis_tdata[OFS_S +: SHOW_W];
            got.tex_t        = m_axis_tdata[OFS_T +: SHOW_W];
            got.corner_a     = m_axis_tdata[OFS_A +: SHOW_W];
            got.corner_b     = m_axis_tdata[OFS_B +: SHOW_W];
            got.corner_c     = m_axis_tdata[OFS_C +: SHOW_W];
            got.pad          = m_axis_tdata[TDATA_W-1:OFS_PAD];
            got.vertex_valid = m_axis_tuser[USR_VERTEX];
            got.tri_valid    = m_axis_tuser[USR_TRI];
            got.done         = m_axis_tuser[USR_DONE];
            if (parsed_q.size() == 0)
            begin
                $error("item with no prediction waiting: tuser %b tdata %h",
                       m_axis_tuser, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = parsed_q.pop_front();
                cmp_field("vertex_valid", 32'(want.vertex_valid), 32'(got.vertex_valid));
                cmp_field("vertex_serial", 32'(want.serial), 32'(got.serial));
                cmp_field("vert_index", 32'(want.vert), 32'(got.vert));
                cmp_field("norm_index", 32'(want.norm), 32'(got.norm));
                cmp_field("tex_s", 32'(want.tex_s), 32'(got.tex_s));
                cmp_field("tex_t", 32'(want.tex_t), 32'(got.tex_t));
                cmp_field("tri_valid", 32'(want.tri_valid), 32'(got.tri_valid));
                cmp_field("corner_a", 32'(want.corner_a), 32'(got.corner_a));
                cmp_field("corner_b", 32'(want.corner_b), 32'(got.corner_b));
                cmp_field("corner_c", 32'(want.corner_c), 32'(got.corner_c));
                cmp_field("stream_done", 32'(want.done), 32'(got.done));
                cmp_field("tdata padding", 32'(want.pad), 32'(got.pad));
                items_checked++;
            end
        end
        @(negedge clk);
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (words_issued < quiet_from && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("strip_fan_command_parser_core verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int  kind;
        int  nv;
        bit  hold;
        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        ph            = PH_HEADER;
        verts_left    = '0;
        strip_on      = 1'b0;
        cmd_pos       = '0;
        serial_next   = '0;
        first_ser     = '0;
        prev_ser      = '0;
        prev2_ser     = '0;
        hold_vert     = '0;
        hold_norm     = '0;
        hold_s        = '0;

        // Directed: end marker straight out of reset, a three-vertex strip
        // with extreme and negative index words, then a three-vertex fan.
        push_word(16'h0000, 1'b0);
        push_word(16'd3, 1'b0);
        push_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        push_vertex(16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF);
        push_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_word(16'hFFFD, 1'b0);
        push_vertex(16'hFFFF, 16'h8000, 16'hFFFF, 16'h0001);
        push_vertex(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        push_vertex(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

        // Random: well-formed strips and fans with random vertex content,
        // end markers mixed in, and short commands that make no triangle.
        next_hold_at = HOLD_EVERY;
        while (cmd_q.size() < 1100)
        begin
            hold = 1'b0;
            if (cmd_q.size() > next_hold_at)
            begin
                hold = 1'b1;
                next_hold_at += HOLD_EVERY;
            end
            kind = $urandom_range(0, 15);
            if (kind == 0)
                push_word(16'h0000, hold);
            else
            begin
                nv = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                 : $urandom_range(3, 12);
                push_word(kind[0] ? 16'(nv) : 16'(-nv), hold);
                repeat (nv)
                    push_random_vertex();
            end
        end
        // Tail: the largest fan header; the stream stops partway through it.
        push_word(16'h8000, 1'b0);
        repeat (12)
            push_random_vertex();

        words_total = cmd_q.size();
        quiet_from = words_total - QUIET_TAIL;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (words_taken < words_total || parsed_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d command words: %0d strips, %0d fans, %0d end markers.",
                 words_total, n_strip, n_fan, n_done);
        $display("Checked %0d items: %0d vertices, %0d triangles.",
                 items_checked, n_vertex, n_tri);
        if (fail_count == 0)
            $display("strip_fan_command_parser_core verification clean");
        else
            $display("strip_fan_command_parser_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
